### hw/rtl/srds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srds_pkg;

  localparam int WordWidth  = 16;
  localparam int MaxResults = 16;

  // Port widths, fixed
  localparam int DeltaW   = 16;
  localparam int RankOutW = 5;
  localparam int CfgW     = 4;
  localparam int CfgIdxW  = 2;

  localparam int RotW      = $clog2(WordWidth);
  localparam int RowIdxW   = $clog2(WordWidth);
  localparam int RankW     = $clog2(WordWidth + 1);
  localparam int CntW      = $clog2(MaxResults + 1);
  localparam int NumStages = WordWidth + 1;

  localparam logic [CfgW-1:0] RotAndFirstRst  = 4'd1;
  localparam logic [CfgW-1:0] RotAndSecondRst = 4'd8;
  localparam logic [CfgW-1:0] RotLinearRst    = 4'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRotAndFirst  = 2'd0,
    CfgRotAndSecond = 2'd1,
    CfgRotLinear    = 2'd2
  } cfg_idx_e;

  typedef logic [WordWidth-1:0] row_t;
  typedef row_t [WordWidth-1:0] matrix_t;
  typedef logic [RotW-1:0] rot_t;

  typedef struct packed {
    matrix_t          rows;
    row_t             off;
    logic [RankW-1:0] rank;
  } stage_t;

  // Rotation amount modulo the word width
  function automatic rot_t rot_amt(input logic [CfgW-1:0] r);
    logic [7:0] v;
    int k;
    v = 8'(r);
    for (k = 0; k < 4; k++) begin
      if (v >= 8'(WordWidth)) begin
        v = v - 8'(WordWidth);
      end
    end
    return RotW'(v);
  endfunction

  function automatic row_t rotl(input row_t x, input rot_t r);
    logic [2*WordWidth-1:0] tmp;
    tmp = {x, x} << r;
    return tmp[2*WordWidth-1:WordWidth];
  endfunction

  // Row i reduces to (A & rotl(e_i,b)) ^ (rotl(e_i,a) & B) with A, B the
  // rotated delta; the linear term cancels.
  function automatic stage_t gen_rows(input row_t d, input rot_t ra, input rot_t rb,
                                      input rot_t rc);
    stage_t res;
    row_t   a_w;
    row_t   b_w;
    row_t   unit;
    int     i;
    a_w = rotl(d, ra);
    b_w = rotl(d, rb);
    for (i = 0; i < WordWidth; i++) begin
      unit    = '0;
      unit[i] = 1'b1;
      res.rows[i] = (a_w & rotl(unit, rb)) ^ (rotl(unit, ra) & b_w);
    end
    res.off  = rotl(d, rc) ^ (a_w & b_w);
    res.rank = '0;
    return res;
  endfunction

  // One row of the reduction. Rows at and below step hold no bits above the
  // current pivot column, so the pivot is the top bit of their OR.
  function automatic stage_t elim_step(input stage_t st, input logic [RowIdxW-1:0] step);
    stage_t res;
    row_t   orv;
    row_t   piv;
    row_t   cur;
    row_t   pick;
    logic   found;
    int     j;
    int     b;
    res = st;
    orv = '0;
    for (j = 0; j < WordWidth; j++) begin
      if (j >= int'(step)) begin
        orv = orv | st.rows[j];
      end
    end
    piv = '0;
    for (b = 0; b < WordWidth; b++) begin
      if (orv[b]) begin
        piv    = '0;
        piv[b] = 1'b1;
      end
    end
    cur   = st.rows[step];
    pick  = '0;
    found = 1'b0;
    for (j = 0; j < WordWidth; j++) begin
      if (j > int'(step) && !found && (|(st.rows[j] & piv))) begin
        pick  = st.rows[j];
        found = 1'b1;
      end
    end
    if (!(|(cur & piv))) begin
      cur = cur ^ pick;
    end
    res.rows[step] = cur;
    for (j = 0; j < WordWidth; j++) begin
      if (j > int'(step) && (|(st.rows[j] & piv))) begin
        res.rows[j] = st.rows[j] ^ cur;
      end
    end
    if (|(st.off & piv)) begin
      res.off = st.off ^ cur;
    end
    if (|orv) begin
      res.rank = st.rank + RankW'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/simon_round_differential_space.sv
`timescale 1ns / 1ps
`default_nettype none

// Output-difference space of f(x) = rotl(x,c) ^ (rotl(x,a) & rotl(x,b)).
// Input channel: one delta per beat (in_valid_i / in_ready_o).
// Output channel: one beat per nonzero reduced basis row, highest row first,
// each with the reduced offset and the rank; last_o marks the final beat of
// a delta. A delta with rank zero yields one beat with basis_vector_o zero.
// Config channel: cfg_index_i 0..2 selects rot_and_first, rot_and_second,
// rot_linear; always ready; the user must write it only while the block is
// idle, which the block itself does not enforce. Pipeline: one row-generation
// stage, 16 elimination stages of one row each, and the output register.
// Throughput: a delta enters every cycle while the pipe has room; the output
// register sends max(1, rank) beats per delta, one per cycle while out_ready_i
// is high, so the sustained delta rate falls as the rank grows.
// Reset: rotations return to 1, 8 and 2; pipe and output register empty.
// When the receiver stalls, the current beat holds, the pipe fills up and
// in_ready_o drops; nothing is lost or repeated.
module simon_round_differential_space (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [srds_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [srds_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [srds_pkg::DeltaW-1:0]     delta_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [srds_pkg::DeltaW-1:0]     offset_o,
  output logic [srds_pkg::DeltaW-1:0]     basis_vector_o,
  output logic [srds_pkg::RankOutW-1:0]   rank_o,
  output logic                            last_o
);
  import srds_pkg::*;

  logic [CfgW-1:0] rot_first_q;
  logic [CfgW-1:0] rot_second_q;
  logic [CfgW-1:0] rot_linear_q;

  logic [NumStages-1:0] valid_q;
  stage_t               data_q [NumStages];
  logic [NumStages:0]   stage_rdy;

  logic             ser_valid_q, ser_valid_d;
  logic [RowIdxW-1:0] ser_idx_q, ser_idx_d;
  logic [CntW-1:0]  ser_left_q, ser_left_d;
  matrix_t          ser_rows_q;
  row_t             ser_off_q;
  logic [RankW-1:0] ser_rank_q;
  logic             ser_take;
  stage_t           tail;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_first_q  <= RotAndFirstRst;
      rot_second_q <= RotAndSecondRst;
      rot_linear_q <= RotLinearRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRotAndFirst:  rot_first_q  <= cfg_data_i;
        CfgRotAndSecond: rot_second_q <= cfg_data_i;
        CfgRotLinear:    rot_linear_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = stage_rdy[0];
  assign stage_rdy[NumStages] = ser_take;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    stage_t nxt;
    logic   up_valid;

    if (s == 0) begin : g_gen
      assign up_valid = in_valid_i;
      assign nxt = gen_rows(WordWidth'(delta_i), rot_amt(rot_first_q),
                            rot_amt(rot_second_q), rot_amt(rot_linear_q));
    end else begin : g_elim
      assign up_valid = valid_q[s-1];
      assign nxt = elim_step(data_q[s-1], RowIdxW'(s - 1));
    end

    assign stage_rdy[s] = !valid_q[s] || stage_rdy[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (stage_rdy[s]) begin
        valid_q[s] <= up_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_rdy[s] && up_valid) begin
        data_q[s] <= nxt;
      end
    end
  end

  // Output register: walks the reduced rows from rank-1 down
  assign tail     = data_q[NumStages-1];
  assign last_o   = (ser_left_q == CntW'(1));
  assign ser_take = !ser_valid_q || (out_ready_i && last_o);

  always_comb begin
    ser_valid_d = ser_valid_q;
    ser_idx_d   = ser_idx_q;
    ser_left_d  = ser_left_q;
    if (ser_take) begin
      ser_valid_d = valid_q[NumStages-1];
      if (valid_q[NumStages-1]) begin
        if (tail.rank == '0) begin
          ser_idx_d  = '0;
          ser_left_d = CntW'(1);
        end else begin
          ser_idx_d = RowIdxW'(tail.rank - RankW'(1));
          if (32'(tail.rank) > 32'(MaxResults)) begin
            ser_left_d = CntW'(MaxResults);
          end else begin
            ser_left_d = CntW'(tail.rank);
          end
        end
      end
    end else if (out_ready_i) begin
      ser_idx_d  = ser_idx_q - RowIdxW'(1);
      ser_left_d = ser_left_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      ser_idx_q   <= '0;
      ser_left_q  <= '0;
    end else begin
      ser_valid_q <= ser_valid_d;
      ser_idx_q   <= ser_idx_d;
      ser_left_q  <= ser_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_take && valid_q[NumStages-1]) begin
      ser_rows_q <= tail.rows;
      ser_off_q  <= tail.off;
      ser_rank_q <= tail.rank;
    end
  end

  assign out_valid_o    = ser_valid_q;
  assign offset_o       = DeltaW'(ser_off_q);
  assign basis_vector_o = DeltaW'(ser_rows_q[ser_idx_q]);
  assign rank_o         = RankOutW'(ser_rank_q);

endmodule

`default_nettype wire

### hw/rtl/srds_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module srds_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  logic [srds_pkg::DeltaW-1:0]     offset_o,
  input  logic [srds_pkg::DeltaW-1:0]     basis_vector_o,
  input  logic [srds_pkg::RankOutW-1:0]   rank_o,
  input  logic                            last_o
);
  import srds_pkg::*;

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(offset_o)
      && $stable(basis_vector_o) && $stable(rank_o) && $stable(last_o))
    else $error("output beat changed while stalled");

  // rank zero: one beat, zero basis
  a_rank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rank_o == '0 |-> last_o && basis_vector_o == '0)
    else $error("rank zero beat malformed");

  a_basis_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rank_o != '0 |-> basis_vector_o != '0)
    else $error("zero basis vector with nonzero rank");

  // beats of one delta follow back to back with the same offset and rank
  a_same_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o && $stable(offset_o)
      && $stable(rank_o))
    else $error("offset or rank changed within one delta");

  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(rank_o) <= 32'(WordWidth))
    else $error("rank above word width");

endmodule

bind simon_round_differential_space srds_checker u_srds_checker (.*);

`default_nettype wire
